/* hdl/mrqd_pkg.sv */
`default_nettype none

package mrqd_pkg;

   localparam int DEF_QUEUE_DEPTH      = 16;
   localparam int DEF_CONTROLLER_COUNT = 4;
   localparam int DEF_MAX_REPORT_LEN   = 8;

   // widest controller index that any legal controller count needs
   localparam int CTRL_W   = 3;
   localparam int MAX_CTRL = 8;

   localparam logic [1:0] ACT_REPORT     = 2'd0;
   localparam logic [1:0] ACT_CONNECT    = 2'd1;
   localparam logic [1:0] ACT_DISCONNECT = 2'd2;
   localparam logic [1:0] ACT_REQUEST    = 2'd3;

   localparam logic [2:0] OP_POLL    = 3'd0;
   localparam logic [2:0] OP_BUTTONS = 3'd1;
   localparam logic [2:0] OP_DEVICES = 3'd2;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_EVENT   = 3'd1;
   localparam logic [2:0] KIND_LOST    = 3'd2;
   localparam logic [2:0] KIND_BAD     = 3'd3;
   localparam logic [2:0] KIND_DEVICES = 3'd4;
   localparam logic [2:0] KIND_BUTTONS = 3'd5;

   localparam logic [7:0] SHORT_LEN = 8'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] controller;
      logic [7:0] report_length;
      logic [7:0] button_byte;
      logic [7:0] move_x;
      logic [7:0] move_y;
      logic [2:0] operation;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  event_controller;
      logic [7:0]  event_dx;
      logic [7:0]  event_dy;
      logic [2:0]  button_bits;
      logic [3:0]  device_mask;
      logic [31:0] dropped_count;
      logic [31:0] malformed_count;
      logic [31:0] decoded_count;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_CONNECT,
      CMD_DISCONNECT,
      CMD_BAD,
      CMD_POLL,
      CMD_BUTTONS,
      CMD_DEVICES
   } cmd_kind_type;

   typedef struct packed {
      logic [CTRL_W-1:0] ctrl;
      logic              is_short;
      logic [2:0]        buttons;
      logic [7:0]        dx;
      logic [7:0]        dy;
   } entry_type;

   typedef struct packed {
      cmd_kind_type kind;
      entry_type    entry;
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/mrqd_front.sv */
`default_nettype none

module mrqd_front
   import mrqd_pkg::*;
#(
   parameter int CONTROLLER_COUNT = DEF_CONTROLLER_COUNT,
   parameter int MAX_REPORT_LEN   = DEF_MAX_REPORT_LEN
) (
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  wire logic    cmd_full
);

   logic ctrl_ok;
   logic len_ok;
   logic keep;

   assign ctrl_ok = req_payload.controller < 8'(CONTROLLER_COUNT);
   assign len_ok  = req_payload.report_length <= 8'(MAX_REPORT_LEN);

   always_comb begin
      keep               = 1'b1;
      cmd.kind           = CMD_BAD;
      cmd.entry.ctrl     = req_payload.controller[CTRL_W-1:0];
      cmd.entry.is_short = req_payload.report_length < SHORT_LEN;
      cmd.entry.buttons  = req_payload.button_byte[2:0];
      cmd.entry.dx       = req_payload.move_x;
      cmd.entry.dy       = req_payload.move_y;
      case (req_payload.action)
         ACT_REPORT: begin
            cmd.kind = CMD_PUSH;
            keep     = ctrl_ok && len_ok;
         end
         ACT_CONNECT: begin
            cmd.kind = CMD_CONNECT;
            keep     = ctrl_ok;
         end
         ACT_DISCONNECT: begin
            cmd.kind = CMD_DISCONNECT;
            keep     = ctrl_ok;
         end
         default: begin
            case (req_payload.operation)
               OP_POLL:    cmd.kind = CMD_POLL;
               OP_BUTTONS: cmd.kind = CMD_BUTTONS;
               OP_DEVICES: cmd.kind = CMD_DEVICES;
               default:    cmd.kind = CMD_BAD;
            endcase
         end
      endcase
   end

   // ignored transactions are accepted and dropped here
   assign cmd_valid = req_valid && keep;
   assign req_stall = cmd_full;

endmodule

`default_nettype wire

/* hdl/mrqd_cmd_fifo.sv */
`default_nettype none

module mrqd_cmd_fifo
   import mrqd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* hdl/mrqd_back.sv */
`default_nettype none

module mrqd_back
   import mrqd_pkg::*;
#(
   parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
   parameter int CONTROLLER_COUNT = DEF_CONTROLLER_COUNT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   localparam int PW  = $clog2(QUEUE_DEPTH);
   localparam int CIW = (CONTROLLER_COUNT > 1) ? $clog2(CONTROLLER_COUNT) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_READ,
      ST_SCAN_CHECK
   } state_type;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;
   logic      mem_we;
   logic      rd_en;

   state_type             state_ff, state_in;
   logic [PW-1:0]         wp_ff, wp_in;
   logic [PW-1:0]         rp_ff, rp_in;
   logic [CONTROLLER_COUNT-1:0] mask_ff, mask_in;
   logic [2:0]            held_ff [CONTROLLER_COUNT];
   logic [2:0]            held_in [CONTROLLER_COUNT];
   logic                  loss_ff, loss_in;
   logic [31:0]           drop_ff, drop_in;
   logic [31:0]           malf_ff, malf_in;
   logic [31:0]           dec_ff, dec_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               res_in;
   logic                  res_load;

   logic                  out_free;
   logic                  needs_rsp;
   logic [PW-1:0]         wp_next;
   logic [PW-1:0]         rp_next;
   logic [CIW-1:0]        cmd_idx;
   logic [CIW-1:0]        ent_idx;
   logic [2:0]            btn_or;
   logic [MAX_CTRL-1:0]   mask_wide;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign needs_rsp = (cmd.kind == CMD_BAD) || (cmd.kind == CMD_POLL) ||
                      (cmd.kind == CMD_BUTTONS) || (cmd.kind == CMD_DEVICES);
   assign wp_next   = ring_next(wp_ff);
   assign rp_next   = ring_next(rp_ff);
   assign cmd_idx   = cmd.entry.ctrl[CIW-1:0];
   assign ent_idx   = rd_data_ff.ctrl[CIW-1:0];
   assign mask_wide = MAX_CTRL'(mask_ff);

   always_comb begin
      btn_or = 3'd0;
      for (int i = 0; i < CONTROLLER_COUNT; i++) begin
         if (mask_ff[i]) begin
            btn_or = btn_or | held_ff[i];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      mask_in      = mask_ff;
      held_in      = held_ff;
      loss_in      = loss_ff;
      drop_in      = drop_ff;
      malf_in      = malf_ff;
      dec_in       = dec_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      res_load     = 1'b0;
      res_in                 = '0;
      res_in.dropped_count   = drop_ff;
      res_in.malformed_count = malf_ff;
      res_in.decoded_count   = dec_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && (!needs_rsp || out_free)) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_PUSH: begin
                     if (wp_next == rp_ff) begin
                        drop_in = drop_ff + 32'd1;
                        loss_in = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        wp_in  = wp_next;
                     end
                  end
                  CMD_CONNECT: begin
                     mask_in[cmd_idx] = 1'b1;
                  end
                  CMD_DISCONNECT: begin
                     mask_in[cmd_idx] = 1'b0;
                     drop_in          = drop_ff + 32'd1;
                     loss_in          = 1'b1;
                  end
                  CMD_BAD: begin
                     res_load    = 1'b1;
                     res_in.kind = KIND_BAD;
                  end
                  default: begin
                     for (int i = 0; i < CONTROLLER_COUNT; i++) begin
                        if (!mask_ff[i]) begin
                           held_in[i] = 3'd0;
                        end
                     end
                     if (loss_ff) begin
                        loss_in = 1'b0;
                        rp_in   = wp_ff;
                        for (int i = 0; i < CONTROLLER_COUNT; i++) begin
                           held_in[i] = 3'd0;
                        end
                        res_load    = 1'b1;
                        res_in.kind = KIND_LOST;
                     end else if (cmd.kind == CMD_DEVICES) begin
                        res_load           = 1'b1;
                        res_in.kind        = KIND_DEVICES;
                        res_in.device_mask = mask_wide[3:0];
                     end else if (cmd.kind == CMD_BUTTONS) begin
                        res_load           = 1'b1;
                        res_in.kind        = KIND_BUTTONS;
                        res_in.button_bits = btn_or;
                     end else begin
                        state_in = ST_SCAN_READ;
                     end
                  end
               endcase
            end
         end
         ST_SCAN_READ: begin
            // output slot was free at dispatch and only drains meanwhile
            if (rp_ff == wp_ff) begin
               res_load    = 1'b1;
               res_in.kind = KIND_NONE;
               state_in    = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rp_in    = rp_next;
               state_in = ST_SCAN_CHECK;
            end
         end
         ST_SCAN_CHECK: begin
            if (rd_data_ff.is_short) begin
               malf_in  = malf_ff + 32'd1;
               state_in = ST_SCAN_READ;
            end else if (!mask_ff[ent_idx]) begin
               state_in = ST_SCAN_READ;
            end else begin
               held_in[ent_idx]        = rd_data_ff.buttons;
               dec_in                  = dec_ff + 32'd1;
               res_load                = 1'b1;
               res_in.kind             = KIND_EVENT;
               res_in.event_controller = rd_data_ff.ctrl[1:0];
               res_in.event_dx         = rd_data_ff.dx;
               res_in.event_dy         = rd_data_ff.dy;
               res_in.button_bits      = rd_data_ff.buttons;
               res_in.decoded_count    = dec_ff + 32'd1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         mask_ff      <= '0;
         loss_ff      <= 1'b0;
         drop_ff      <= 32'd0;
         malf_ff      <= 32'd0;
         dec_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CONTROLLER_COUNT; i++) begin
            held_ff[i] <= 3'd0;
         end
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         mask_ff      <= mask_in;
         loss_ff      <= loss_in;
         drop_ff      <= drop_in;
         malf_ff      <= malf_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
      end
      if (res_load) begin
         rsp_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= cmd.entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rp_ff];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* hdl/mouse_report_queue_decoder.sv */
// Channel   Ports                              Direction  Moves
// req       req_valid, req_stall, req_payload  in         report/connect/disconnect/request
// rsp       rsp_valid, rsp_stall, rsp_payload  out        one result per request
//
// Front decodes each transaction as it is accepted into a two-entry command queue;
// req_stall rises only when that queue is full.
// Back runs one command at a time; a poll alternates ST_SCAN_READ and ST_SCAN_CHECK per
// ring entry examined, then takes ST_SCAN_READ once more when it ends on an empty ring.
// A request waits in the queue while an earlier result is held by rsp_stall.
// Synchronous reset empties the ring and clears mask, buttons and counters.
`default_nettype none

module mouse_report_queue_decoder
   import mrqd_pkg::*;
#(
   parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
   parameter int CONTROLLER_COUNT = DEF_CONTROLLER_COUNT,
   parameter int MAX_REPORT_LEN   = DEF_MAX_REPORT_LEN
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic    front_valid;
   cmd_type front_cmd;
   logic    fifo_full;
   logic    fifo_valid;
   cmd_type fifo_cmd;
   logic    fifo_pop;

   mrqd_front #(
      .CONTROLLER_COUNT (CONTROLLER_COUNT),
      .MAX_REPORT_LEN   (MAX_REPORT_LEN)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (front_valid),
      .cmd         (front_cmd),
      .cmd_full    (fifo_full)
   );

   mrqd_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_cmd  (front_cmd),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_valid (fifo_valid),
      .pop_cmd   (fifo_cmd)
   );

   mrqd_back #(
      .QUEUE_DEPTH      (QUEUE_DEPTH),
      .CONTROLLER_COUNT (CONTROLLER_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (fifo_valid),
      .cmd         (fifo_cmd),
      .cmd_pop     (fifo_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* tb/mouse_report_queue_decoder_tb.sv */
`timescale 1ns / 100ps

module mouse_report_queue_decoder_tb;
   import mrqd_pkg::*;

   localparam int QDEPTH     = DEF_QUEUE_DEPTH;
   localparam int CTRL_COUNT = DEF_CONTROLLER_COUNT;
   localparam int MAX_LEN    = DEF_MAX_REPORT_LEN;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int DRAIN_CYCLES    = 2 * QDEPTH + 8;

   typedef struct {
      logic [7:0] ctrl;
      bit         is_short;
      logic [2:0] btn;
      logic [7:0] dx;
      logic [7:0] dy;
   } report_entry;

   typedef struct {
      req_type pl;
      bit      hold_off;
   } queued_tx;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   mouse_report_queue_decoder #(
      .QUEUE_DEPTH      (QDEPTH),
      .CONTROLLER_COUNT (CTRL_COUNT),
      .MAX_REPORT_LEN   (MAX_LEN)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predicted decoder state
   report_entry           ring [QDEPTH];
   int                    wr_ptr = 0;
   int                    rd_ptr = 0;
   logic [CTRL_COUNT-1:0] conn_mask = '0;
   logic [2:0]            held [CTRL_COUNT];
   bit                    loss_flag = 1'b0;
   logic [31:0]           drops = '0;
   logic [31:0]           malformed = '0;
   logic [31:0]           decoded = '0;

   queued_tx tx_backlog [$];
   rsp_type  answers_due [$];
   int       issued_cnt = 0;
   int       accepted_cnt = 0;
   int       checked_cnt = 0;
   int       event_cnt = 0;
   int       lost_cnt = 0;
   int       error_count = 0;
   int       work_added = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   bit       answered;
   rsp_type  predicted;

   initial begin
      for (int i = 0; i < CTRL_COUNT; i++) held[i] = '0;
   end

   function automatic void decode_tx(input req_type r, output bit has_answer,
                                     output rsp_type a);
      int         nxt;
      int         n;
      bit         found;
      report_entry e;
      logic [2:0] acc;
      a = '0;
      has_answer = 1'b0;
      found = 1'b0;
      acc = '0;
      case (r.action)
         ACT_REPORT: begin
            if (r.controller < CTRL_COUNT && r.report_length <= MAX_LEN) begin
               nxt = (wr_ptr + 1) % QDEPTH;
               if (nxt == rd_ptr) begin
                  drops++;
                  loss_flag = 1'b1;
               end else begin
                  ring[wr_ptr].ctrl     = r.controller;
                  ring[wr_ptr].is_short = r.report_length < SHORT_LEN;
                  ring[wr_ptr].btn      = r.button_byte[2:0];
                  ring[wr_ptr].dx       = r.move_x;
                  ring[wr_ptr].dy       = r.move_y;
                  wr_ptr = nxt;
               end
            end
         end
         ACT_CONNECT: begin
            if (r.controller < CTRL_COUNT) conn_mask[r.controller] = 1'b1;
         end
         ACT_DISCONNECT: begin
            if (r.controller < CTRL_COUNT) begin
               conn_mask[r.controller] = 1'b0;
               drops++;
               loss_flag = 1'b1;
            end
         end
         default: begin
            has_answer = 1'b1;
            if (r.operation > OP_DEVICES) begin
               a.kind = KIND_BAD;
            end else begin
               for (int i = 0; i < CTRL_COUNT; i++)
                  if (!conn_mask[i]) held[i] = '0;
               if (loss_flag) begin
                  loss_flag = 1'b0;
                  rd_ptr = wr_ptr;
                  for (int i = 0; i < CTRL_COUNT; i++) held[i] = '0;
                  a.kind = KIND_LOST;
               end else if (r.operation == OP_DEVICES) begin
                  a.kind = KIND_DEVICES;
                  a.device_mask = conn_mask;
               end else if (r.operation == OP_BUTTONS) begin
                  for (int i = 0; i < CTRL_COUNT; i++) acc |= held[i];
                  a.kind = KIND_BUTTONS;
                  a.button_bits = acc;
               end else begin
                  a.kind = KIND_NONE;
                  for (n = 0; n < QDEPTH && !found && rd_ptr != wr_ptr; n++) begin
                     e = ring[rd_ptr];
                     rd_ptr = (rd_ptr + 1) % QDEPTH;
                     if (e.is_short) begin
                        malformed++;
                     end else if (conn_mask[e.ctrl]) begin
                        held[e.ctrl] = e.btn;
                        decoded++;
                        a.kind = KIND_EVENT;
                        a.event_controller = e.ctrl[1:0];
                        a.event_dx = e.dx;
                        a.event_dy = e.dy;
                        a.button_bits = e.btn;
                        found = 1'b1;
                     end
                  end
               end
            end
            a.dropped_count   = drops;
            a.malformed_count = malformed;
            a.decoded_count   = decoded;
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (answers_due.size() == 0) begin
         $error("result with nothing outstanding: kind %0d", got.kind);
         error_count++;
      end else begin
         want = answers_due.pop_front();
         checked_cnt++;
         check_field("kind", want.kind, got.kind);
         check_field("event_controller", want.event_controller, got.event_controller);
         check_field("event_dx", want.event_dx, got.event_dx);
         check_field("event_dy", want.event_dy, got.event_dy);
         check_field("button_bits", want.button_bits, got.button_bits);
         check_field("device_mask", want.device_mask, got.device_mask);
         check_field("dropped_count", want.dropped_count, got.dropped_count);
         check_field("malformed_count", want.malformed_count, got.malformed_count);
         check_field("decoded_count", want.decoded_count, got.decoded_count);
      end
   endfunction

   // monitor: results are checked before this edge's transaction is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_result(rsp_payload);
         if (req_valid && !req_stall) begin
            accepted_cnt++;
            decode_tx(req_payload, answered, predicted);
            if (answered) begin
               answers_due.push_back(predicted);
               if (predicted.kind == KIND_EVENT) event_cnt++;
               if (predicted.kind == KIND_LOST) lost_cnt++;
            end
         end
      end
   end

   // driver: a held transaction stays put until the monitor has seen it accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || accepted_cnt == issued_cnt) begin
         if (tx_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
             !(tx_backlog[0].hold_off && answers_due.size() != 0)) begin
            req_payload <= tx_backlog[0].pl;
            req_valid   <= 1'b1;
            tx_backlog.delete(0);
            issued_cnt++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   function automatic req_type mk(int act, int ctrl, int len, int b0, int x, int y,
                                  int op);
      req_type r;
      r.action        = 2'(act);
      r.controller    = 8'(ctrl);
      r.report_length = 8'(len);
      r.button_byte   = 8'(b0);
      r.move_x        = 8'(x);
      r.move_y        = 8'(y);
      r.operation     = 3'(op);
      return r;
   endfunction

   function automatic bit counts_as_work(req_type r);
      case (r.action)
         ACT_REPORT:                  return r.controller < CTRL_COUNT &&
                                             r.report_length <= MAX_LEN;
         ACT_CONNECT, ACT_DISCONNECT: return r.controller < CTRL_COUNT;
         default:                     return 1'b1;
      endcase
   endfunction

   task automatic queue_tx(req_type r, bit hold = 1'b0);
      queued_tx q;
      q.pl = r;
      q.hold_off = hold;
      tx_backlog.push_back(q);
      if (counts_as_work(r)) work_added++;
   endtask

   function automatic req_type rand_report(bit well_formed);
      req_type r;
      int      pick;
      r = mk(ACT_REPORT, $urandom_range(0, 255), $urandom_range(3, MAX_LEN),
             $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 7));
      if (well_formed) r.controller = 8'($urandom_range(0, CTRL_COUNT - 1));
      pick = $urandom_range(0, 9);
      if (pick == 0) r.report_length = 8'($urandom_range(0, SHORT_LEN - 1));
      else if (pick == 1 && !well_formed)
         r.report_length = 8'($urandom_range(MAX_LEN + 1, 255));
      return r;
   endfunction

   function automatic req_type rand_request();
      int pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 70) op = OP_POLL;
      else if (pick < 80) op = OP_BUTTONS;
      else if (pick < 90) op = OP_DEVICES;
      else op = 3'($urandom_range(OP_DEVICES + 1, 7));
      return mk(ACT_REQUEST, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), op);
   endfunction

   task automatic add_sequence();
      int      pick;
      int      n;
      bit      hold;
      req_type r;
      pick = $urandom_range(0, 99);
      hold = ($urandom_range(0, 29) == 0);
      if (pick < 55) begin
         // burst of reports then a run of requests; long bursts overflow the ring
         if ($urandom_range(0, 2) == 0)
            queue_tx(mk(ACT_CONNECT, $urandom_range(0, CTRL_COUNT - 1), 0, 0, 0, 0, 0), hold);
         n = $urandom_range(1, QDEPTH + 4);
         for (int i = 0; i < n; i++) queue_tx(rand_report($urandom_range(0, 9) != 0));
         n = $urandom_range(1, n + 3);
         for (int i = 0; i < n; i++) queue_tx(rand_request());
      end else if (pick < 75) begin
         r = mk($urandom_range(0, 3) == 0 ? ACT_DISCONNECT : ACT_CONNECT,
                $urandom_range(0, CTRL_COUNT - 1), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 7));
         queue_tx(r, hold);
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) queue_tx(rand_request());
      end else begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++)
            queue_tx(mk($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 7)), hold && i == 0);
      end
   endtask

   task automatic wait_quiet();
      while (tx_backlog.size() != 0 || accepted_cnt != issued_cnt || answers_due.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      // directed: empty queue, every request kind, range limits, short entries
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_POLL));
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_BUTTONS));
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_DEVICES));
      queue_tx(mk(ACT_REQUEST, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 3'd7));
      queue_tx(mk(ACT_CONNECT, 0, 0, 0, 0, 0, 0));
      queue_tx(mk(ACT_CONNECT, CTRL_COUNT - 1, 0, 0, 0, 0, 0));
      queue_tx(mk(ACT_CONNECT, 200, 0, 0, 0, 0, 0));
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_DEVICES));
      queue_tx(mk(ACT_REPORT, 0, SHORT_LEN, 8'hff, 8'h00, 8'hff, 0));
      queue_tx(mk(ACT_REPORT, CTRL_COUNT - 1, MAX_LEN, 8'h05, 8'h80, 8'h01, 0));
      queue_tx(mk(ACT_REPORT, 1, 4, 8'h02, 8'h11, 8'h22, 0));
      queue_tx(mk(ACT_REPORT, 0, SHORT_LEN - 1, 8'h07, 8'h33, 8'h44, 0));
      queue_tx(mk(ACT_REPORT, 0, MAX_LEN + 1, 8'h07, 8'h55, 8'h66, 0));
      queue_tx(mk(ACT_REPORT, 0, 8'hff, 8'h07, 8'h77, 8'h88, 0));
      queue_tx(mk(ACT_REPORT, 8'hff, SHORT_LEN, 8'h07, 8'h99, 8'haa, 0));
      queue_tx(mk(ACT_REPORT, CTRL_COUNT - 1, 0, 8'h03, 8'hbb, 8'hcc, 0));
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_POLL));
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_POLL));
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_POLL));
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_BUTTONS));
      queue_tx(mk(ACT_DISCONNECT, CTRL_COUNT - 1, 0, 0, 0, 0, 0));
      queue_tx(mk(ACT_DISCONNECT, 200, 0, 0, 0, 0, 0));
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_BUTTONS), 1'b1);
      queue_tx(mk(ACT_REQUEST, 0, 0, 0, 0, 0, OP_POLL));
      queue_tx(mk(ACT_CONNECT, CTRL_COUNT - 1, 0, 0, 0, 0, 0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_quiet();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 79; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
         endcase
         work_added = 0;
         while (work_added < ITEMS_PER_PHASE) add_sequence();
         wait_quiet();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (answers_due.size() != 0) begin
         $error("%0d results never arrived", answers_due.size());
         error_count++;
      end
      $display("Ran %0d transactions, checked %0d results: %0d events, %0d loss answers,",
               accepted_cnt, checked_cnt, event_cnt, lost_cnt);
      $display("  %0d drops, %0d malformed entries, under four idle/stall mixes.",
               drops, malformed);
      if (error_count == 0)
         $display("** mouse_report_queue_decoder: PASSED **");
      else
         $display("** mouse_report_queue_decoder: FAILED **");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results outstanding", answers_due.size());
      $display("** mouse_report_queue_decoder: FAILED **");
      $finish;
   end

endmodule
